>>> rtl/core/sm4cbc_pkg.sv
// SM4-CBC shared definitions: S-box, key schedule constants, round functions,
// register indexes and the request struct to the round key store.
// No dependencies.
`default_nettype none

package sm4cbc_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int RK_AW       = $clog2(ROUND_COUNT);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_LOW  = 2'd1,
        CFG_IV_HIGH  = 2'd2,
        CFG_IV_LOW   = 2'd3
    } t_cfg_idx;

    // Request from the controller to the round key store
    typedef struct packed {
        logic             expand;
        logic [RK_AW-1:0] rd_addr;
    } t_rk_req;

    localparam logic [127:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

    localparam logic [7:0] SBOX [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    localparam logic [31:0] CK [0:ROUND_COUNT-1] = '{
        32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269,
        32'h70777e85, 32'h8c939aa1, 32'ha8afb6bd, 32'hc4cbd2d9,
        32'he0e7eef5, 32'hfc030a11, 32'h181f262d, 32'h343b4249,
        32'h50575e65, 32'h6c737a81, 32'h888f969d, 32'ha4abb2b9,
        32'hc0c7ced5, 32'hdce3eaf1, 32'hf8ff060d, 32'h141b2229,
        32'h30373e45, 32'h4c535a61, 32'h686f767d, 32'h848b9299,
        32'ha0a7aeb5, 32'hbcc3cad1, 32'hd8dfe6ed, 32'hf4fb0209,
        32'h10171e25, 32'h2c333a41, 32'h484f565d, 32'h646b7279
    };

    // Substitute each byte of a word through the S-box
    function automatic logic [31:0] sub_word(input logic [31:0] x);
        logic [31:0] b;
        for (int i = 0; i < 4; i++) begin
            b[8*i +: 8] = SBOX[x[8*i +: 8]];
        end
        return b;
    endfunction

    // Linear transform of the data rounds
    function automatic logic [31:0] data_t(input logic [31:0] x);
        logic [31:0] b;
        b = sub_word(x);
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    // Linear transform of the key schedule
    function automatic logic [31:0] key_t(input logic [31:0] x);
        logic [31:0] b;
        b = sub_word(x);
        return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/sm4cbc_rkey_store.sv
// SM4-CBC round key store: key expansion sequencer and the round key memory.
// Depends on sm4cbc_pkg.
`default_nettype none

module sm4cbc_rkey_store (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [127:0]             i_key,
    input  wire sm4cbc_pkg::t_rk_req      i_req,
    output logic [31:0]                   o_rk,
    output logic                          o_expand_done
);
    import sm4cbc_pkg::*;

    logic [31:0]      r_mem [0:ROUND_COUNT-1];
    logic [31:0]      r_rd_data;
    logic             r_busy;
    logic [RK_AW-1:0] r_cnt;
    logic [127:0]     r_k;
    logic [31:0]      n_rk;

    // Next round key from the sliding window of four words
    assign n_rk = r_k[127:96] ^ key_t(r_k[95:64] ^ r_k[63:32] ^ r_k[31:0] ^ CK[r_cnt]);

    assign o_expand_done = r_busy && (r_cnt == RK_AW'(ROUND_COUNT - 1));
    assign o_rk          = r_rd_data;

    // Run the expansion sequence, one round key a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.expand) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_expand_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Hold and shift the key window
    always_ff @(posedge i_clk) begin
        if (i_req.expand) begin
            r_k <= i_key ^ FK;
        end else if (r_busy) begin
            r_k <= {r_k[95:0], n_rk};
        end
    end

    // Write expanded keys; registered read port
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_cnt] <= n_rk;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/sm4_cbc_block_cipher.sv
// SM4-CBC block cipher top level: request handshakes, padding, chaining and
// the round datapath. Depends on sm4cbc_pkg and sm4cbc_rkey_store.
//
//  Channel  | Direction | Handshake                   | Payload
//  ---------+-----------+-----------------------------+------------------------------
//  in       | into      | i_in_valid / o_in_stall     | mode, block halves, marks, count
//  out      | out of    | o_out_valid / i_out_stall   | out halves, valid_bytes, run_end
//  cfg      | into      | i_cfg_we                    | i_cfg_index, i_cfg_data
//
// After a request is accepted, a round key read set-up state (ST_LOAD) runs,
// then 32 rounds at one round per cycle through the round key memory's read
// port, then ST_DONE passes the result to the output register. The input
// stalls throughout and accepts again in the cycle after the result is loaded.
// The first request after reset or a key write runs the key expansion first.
// A full final encrypt block runs the rounds twice. Reset is synchronous and
// active low. While the output register is held by i_out_stall a finished
// result waits in place.
`default_nettype none

module sm4_cbc_block_cipher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    // requests
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_mode,
    input  wire logic [63:0] i_block_high,
    input  wire logic [63:0] i_block_low,
    input  wire logic        i_first_block,
    input  wire logic        i_final_block,
    input  wire logic [4:0]  i_byte_count,
    // results
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_out_high,
    output logic [63:0]      o_out_low,
    output logic [4:0]       o_valid_bytes,
    output logic             o_run_end
);
    import sm4cbc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } t_state;

    t_state           r_state;
    logic [63:0]      r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic             r_keys_ready;
    logic [127:0]     r_chain;
    logic [127:0]     r_ct;
    logic [127:0]     r_x;
    logic             r_dec, r_final, r_extra;
    logic [RK_AW-1:0] r_cnt;
    logic             r_out_valid;
    logic [63:0]      r_out_high, r_out_low;
    logic [4:0]       r_out_vb;
    logic             r_out_end;

    t_rk_req          rk_req;
    logic [31:0]      rk;
    logic             expand_done;
    logic             in_accept;
    logic             out_free;
    logic [127:0]     in_blk, pad_blk, chain_eff;
    logic [4:0]       count_c;
    logic [RK_AW-1:0] rd_idx;
    logic [31:0]      round_t;
    logic [127:0]     w_rounds, w_dec;
    logic [4:0]       dec_vb;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_high  = r_out_high;
    assign o_out_low   = r_out_low;
    assign o_valid_bytes = r_out_vb;
    assign o_run_end   = r_out_end;

    // Round key store: expand on a request that finds the keys stale
    assign rd_idx = (r_state == ST_ROUND) ? r_cnt + 1'b1 : '0;
    assign rk_req = '{expand:  in_accept && !r_keys_ready,
                      rd_addr: r_dec ? ~rd_idx : rd_idx};

    sm4cbc_rkey_store u_rkey_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key         ({r_key_high, r_key_low}),
        .i_req         (rk_req),
        .o_rk          (rk),
        .o_expand_done (expand_done)
    );

    // Pad a short final encrypt block: zeros, then the pad length
    assign in_blk    = {i_block_high, i_block_low};
    assign count_c   = (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
    assign chain_eff = i_first_block ? {r_iv_high, r_iv_low} : r_chain;

    always_comb begin
        pad_blk = in_blk;
        if (i_final_block && (count_c != 5'd16)) begin
            for (int i = 0; i < 15; i++) begin
                if (5'(i) >= count_c) begin
                    pad_blk[127 - 8*i -: 8] = 8'd0;
                end
            end
            pad_blk[7:0] = 8'(5'd16 - count_c);
        end
    end

    // One round of the cipher
    assign round_t  = r_x[127:96] ^ data_t(r_x[95:64] ^ r_x[63:32] ^ r_x[31:0] ^ rk);
    assign w_rounds = {r_x[31:0], r_x[63:32], r_x[95:64], r_x[127:96]};
    assign w_dec    = w_rounds ^ r_chain;

    // Check the padding of a final decrypt block
    always_comb begin
        logic [7:0] p;
        logic [4:0] lo;
        logic       ok;
        p  = w_dec[7:0];
        ok = (p != 8'd0) && (p <= 8'd16);
        lo = 5'd16 - p[4:0];
        for (int i = 0; i < 15; i++) begin
            if ((5'(i) >= lo) && (w_dec[127 - 8*i -: 8] != 8'd0)) begin
                ok = 1'b0;
            end
        end
        dec_vb = (r_final && ok) ? lo : 5'd16;
    end

    // Configuration registers; a key write marks the round keys stale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_iv_high  <= 64'h0001020304050607;
            r_iv_low   <= 64'h0809616263646566;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                CFG_IV_LOW:   r_iv_low   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: accept, expand, run rounds, hand over the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_keys_ready <= 1'b0;
            r_chain      <= '0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_extra      <= 1'b0;
            r_dec        <= 1'b0;
            r_final      <= 1'b0;
        end else begin
            // load a finished result, or drop the one taken
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // mark the keys stale on a key write, fresh once expanded
            if (i_cfg_we && ((t_cfg_idx'(i_cfg_index) == CFG_KEY_HIGH) ||
                             (t_cfg_idx'(i_cfg_index) == CFG_KEY_LOW))) begin
                r_keys_ready <= 1'b0;
            end else if ((r_state == ST_KEXP) && expand_done) begin
                r_keys_ready <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_dec   <= i_mode;
                        r_final <= i_final_block;
                        r_extra <= !i_mode && i_final_block && (count_c == 5'd16);
                        r_chain <= chain_eff;
                        r_ct    <= in_blk;
                        r_x     <= i_mode ? in_blk : (pad_blk ^ chain_eff);
                        r_state <= r_keys_ready ? ST_LOAD : ST_KEXP;
                    end
                end
                ST_KEXP: begin
                    if (expand_done) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_x   <= {r_x[95:0], round_t};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == RK_AW'(ROUND_COUNT - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        if (r_dec) begin
                            r_out_high <= w_dec[127:64];
                            r_out_low  <= w_dec[63:0];
                            r_out_vb   <= dec_vb;
                            r_out_end  <= 1'b1;
                            r_chain    <= r_ct;
                            r_state    <= ST_IDLE;
                        end else begin
                            r_out_high <= w_rounds[127:64];
                            r_out_low  <= w_rounds[63:0];
                            r_out_vb   <= 5'd16;
                            r_out_end  <= !r_extra;
                            r_chain    <= w_rounds;
                            if (r_extra) begin
                                // follow with the block of padding only
                                r_extra <= 1'b0;
                                r_x     <= {64'd0, 64'd16} ^ w_rounds;
                                r_state <= ST_LOAD;
                            end else begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> dv/sm4_cbc_block_cipher_tb.sv
// Self-checking testbench for sm4_cbc_block_cipher: SM4-CBC requests with padding
// and padding checks, predicted by an in-bench SM4 model and checked per field.
// Depends on sm4cbc_pkg (register indexes) and the RTL of sm4_cbc_block_cipher.

module sm4_cbc_block_cipher_tb;

    localparam int NROUNDS      = 32;
    localparam int WATCHDOG_MAX = 3000;
    localparam int LONG_HOLD    = 500;
    localparam int PHASE_ITEMS  = 310;
    localparam int MAX_PRINTS   = 60;

    typedef logic [0:NROUNDS-1][31:0] t_round_keys;

    typedef struct packed {
        logic        decrypt;
        logic [63:0] blk_hi;
        logic [63:0] blk_lo;
        logic        first_blk;
        logic        final_blk;
        logic [4:0]  nbytes;
    } t_cipher_req;

    typedef struct packed {
        logic [63:0] data_hi;
        logic [63:0] data_lo;
        logic [4:0]  vbytes;
        logic        last_of_run;
    } t_cipher_out;

    localparam logic [7:0] SUBST_BOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // Clock, reset and DUT-facing signals
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    sm4cbc_pkg::t_cfg_idx  cfg_idx   = sm4cbc_pkg::CFG_KEY_HIGH;
    logic [63:0]           cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    t_cipher_req           cur_req   = '0;
    logic                  out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [63:0]           o_out_high;
    logic [63:0]           o_out_low;
    logic [4:0]            o_valid_bytes;
    logic                  o_run_end;

    // Predictor state: register copies, round keys and chaining value
    logic [63:0]  reg_key_hi = '0;
    logic [63:0]  reg_key_lo = '0;
    logic [63:0]  reg_iv_hi  = 64'h0001020304050607;
    logic [63:0]  reg_iv_lo  = 64'h0809616263646566;
    t_round_keys  sched;
    bit           sched_ok   = 1'b0;
    logic [127:0] chain_val  = '0;

    // Stimulus and checking bookkeeping
    t_cipher_req  pending_reqs[$];
    t_cipher_out  cipher_results[$];
    t_round_keys  gen_sched;
    int           queued_count  = 0;
    int           send_idle_max = 0;
    int           recv_idle_max = 0;
    int           hold_asks     = 0;
    int           hold_served   = 0;
    int           fault_count   = 0;
    int           idle_cycles   = 0;

    sm4_cbc_block_cipher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (cur_req.decrypt),
        .i_block_high  (cur_req.blk_hi),
        .i_block_low   (cur_req.blk_lo),
        .i_first_block (cur_req.first_blk),
        .i_final_block (cur_req.final_blk),
        .i_byte_count  (cur_req.nbytes),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_out_high    (o_out_high),
        .o_out_low     (o_out_low),
        .o_valid_bytes (o_valid_bytes),
        .o_run_end     (o_run_end)
    );

    // SM4 building blocks
    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 4; i++) begin
            r[8*i +: 8] = SUBST_BOX[x[8*i +: 8]];
        end
        return r;
    endfunction

    function automatic logic [31:0] data_mix(input logic [31:0] x);
        logic [31:0] b;
        b = subst_word(x);
        return b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
    endfunction

    function automatic logic [31:0] key_mix(input logic [31:0] x);
        logic [31:0] b;
        b = subst_word(x);
        return b ^ rol32(b, 13) ^ rol32(b, 23);
    endfunction

    // Expand a 128-bit key; the round constants follow the 7*n byte pattern
    function automatic t_round_keys key_schedule(input logic [127:0] key);
        logic [31:0] k0, k1, k2, k3, ck, nk;
        t_round_keys rk;
        k0 = key[127:96] ^ 32'ha3b1bac6;
        k1 = key[95:64]  ^ 32'h56aa3350;
        k2 = key[63:32]  ^ 32'h677d9197;
        k3 = key[31:0]   ^ 32'hb27022dc;
        for (int i = 0; i < NROUNDS; i++) begin
            for (int j = 0; j < 4; j++) begin
                ck[31-8*j -: 8] = 8'((4*i + j) * 7);
            end
            nk = k0 ^ key_mix(k1 ^ k2 ^ k3 ^ ck);
            rk[i] = nk;
            k0 = k1; k1 = k2; k2 = k3; k3 = nk;
        end
        return rk;
    endfunction

    // One block through the 32 rounds; decryption walks the keys backwards
    function automatic logic [127:0] sm4_rounds(input logic [127:0] blk,
                                                input t_round_keys rk, input bit inverse);
        logic [31:0] x0, x1, x2, x3, t;
        x0 = blk[127:96]; x1 = blk[95:64]; x2 = blk[63:32]; x3 = blk[31:0];
        for (int i = 0; i < NROUNDS; i++) begin
            t = x0 ^ data_mix(x1 ^ x2 ^ x3 ^ rk[inverse ? NROUNDS-1-i : i]);
            x0 = x1; x1 = x2; x2 = x3; x3 = t;
        end
        return {x3, x2, x1, x0};
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Work out the results of one accepted request and queue them
    task automatic sm4_cbc_predict(input t_cipher_req r);
        logic [127:0] blk;
        logic [7:0]   pad;
        int           cnt;
        int           vb;
        bit           pad_ok;
        if (!sched_ok) begin
            sched    = key_schedule({reg_key_hi, reg_key_lo});
            sched_ok = 1'b1;
        end
        if (r.first_blk)
            chain_val = {reg_iv_hi, reg_iv_lo};
        cnt = (r.nbytes > 16) ? 16 : int'(r.nbytes);
        blk = {r.blk_hi, r.blk_lo};
        if (!r.decrypt) begin
            // pad a short final block: zeros, then the pad length in the last byte
            if (r.final_blk && cnt < 16) begin
                for (int b = cnt; b < 15; b++) begin
                    blk[127-8*b -: 8] = 8'h00;
                end
                blk[7:0] = 8'(16 - cnt);
            end
            blk       = sm4_rounds(blk ^ chain_val, sched, 1'b0);
            chain_val = blk;
            if (r.final_blk && cnt == 16) begin
                // full final block: append a whole padding block
                cipher_results.push_back('{blk[127:64], blk[63:0], 5'd16, 1'b0});
                blk       = sm4_rounds(128'd16 ^ chain_val, sched, 1'b0);
                chain_val = blk;
            end
            cipher_results.push_back('{blk[127:64], blk[63:0], 5'd16, 1'b1});
        end else begin
            blk       = sm4_rounds(blk, sched, 1'b1) ^ chain_val;
            chain_val = {r.blk_hi, r.blk_lo};
            vb        = 16;
            if (r.final_blk) begin
                pad = blk[7:0];
                if (pad >= 1 && pad <= 16) begin
                    pad_ok = 1'b1;
                    for (int b = 16 - pad; b < 15; b++) begin
                        if (blk[127-8*b -: 8] != 8'h00)
                            pad_ok = 1'b0;
                    end
                    if (pad_ok)
                        vb = 16 - pad;
                end
            end
            cipher_results.push_back('{blk[127:64], blk[63:0], 5'(vb), 1'b1});
        end
    endtask

    task automatic log_mismatch(input string msg);
        if (fault_count < MAX_PRINTS)
            $display("MISMATCH: %s", msg);
        fault_count++;
    endtask

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Request driver: present queued requests, idle a drawn number of open cycles
    always @(posedge i_clk) begin
        int send_wait;
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            send_wait = 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                sm4_cbc_predict(cur_req);
                idle_cycles = 0;
                send_wait   = $urandom_range(0, send_idle_max);
            end
            // hold the payload while stalled
            if (!(in_valid && o_in_stall)) begin
                if (send_wait == 0 && pending_reqs.size() != 0) begin
                    cur_req  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    if (send_wait != 0 && (!o_in_stall || $urandom_range(0, 3) == 0))
                        send_wait--;
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check against the oldest expectation, stall at random
    always @(posedge i_clk) begin
        int          recv_wait;
        int          hold_left;
        t_cipher_out want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                idle_cycles = 0;
                if (cipher_results.size() == 0) begin
                    log_mismatch($sformatf("result %h_%h with nothing pending",
                                           o_out_high, o_out_low));
                end else begin
                    want = cipher_results.pop_front();
                    if (o_out_high !== want.data_hi)
                        log_mismatch($sformatf("out_high %h, want %h", o_out_high, want.data_hi));
                    if (o_out_low !== want.data_lo)
                        log_mismatch($sformatf("out_low %h, want %h", o_out_low, want.data_lo));
                    if (o_valid_bytes !== want.vbytes)
                        log_mismatch($sformatf("valid_bytes %0d, want %0d",
                                               o_valid_bytes, want.vbytes));
                    if (o_run_end !== want.last_of_run)
                        log_mismatch($sformatf("run_end %b, want %b",
                                               o_run_end, want.last_of_run));
                end
                recv_wait = $urandom_range(0, recv_idle_max);
            end
            if (hold_served != hold_asks) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            // long hold first, then the per-result wait counted on offered results
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (recv_wait != 0) begin
                if (o_out_valid || $urandom_range(0, 3) == 0)
                    recv_wait--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no accepted request or result
    always @(posedge i_clk) begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("sm4_cbc_block_cipher regression: fail");
            $finish;
        end
    end

    // Stimulus helpers
    task automatic write_reg(input sm4cbc_pkg::t_cfg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            sm4cbc_pkg::CFG_KEY_HIGH: begin reg_key_hi = val; sched_ok = 1'b0; end
            sm4cbc_pkg::CFG_KEY_LOW:  begin reg_key_lo = val; sched_ok = 1'b0; end
            sm4cbc_pkg::CFG_IV_HIGH:  reg_iv_hi = val;
            sm4cbc_pkg::CFG_IV_LOW:   reg_iv_lo = val;
        endcase
        gen_sched = key_schedule({reg_key_hi, reg_key_lo});
    endtask

    task automatic queue_request(input bit dec, input logic [127:0] blk, input bit first,
                                 input bit fin, input logic [4:0] nbytes);
        pending_reqs.push_back('{dec, blk[127:64], blk[63:0], first, fin, nbytes});
        queued_count++;
    endtask

    // Plaintext with n data bytes and a pad; flaw 0 keeps it well formed,
    // 1 gives a zero pad byte, 2 an oversized pad byte, 3 a dirty pad region
    function automatic logic [127:0] padded_plain(input int n, input int flaw);
        logic [127:0] pt;
        pt = rand128();
        for (int b = n; b < 15; b++) begin
            pt[127-8*b -: 8] = 8'h00;
        end
        pt[7:0] = 8'(16 - n);
        case (flaw)
            1: pt[7:0] = 8'h00;
            2: pt[7:0] = 8'($urandom_range(17, 255));
            3: if (n < 15) pt[127-8*$urandom_range(n, 14) -: 8] = 8'($urandom_range(1, 255));
            default: ;
        endcase
        return pt;
    endfunction

    // Single-block decrypt message whose plaintext comes out as given
    task automatic queue_decrypt_of(input logic [127:0] pt, input logic [4:0] nbytes);
        queue_request(1'b1, sm4_rounds(pt ^ {reg_iv_hi, reg_iv_lo}, gen_sched, 1'b0),
                      1'b1, 1'b1, nbytes);
    endtask

    task automatic add_encrypt_message(input int nblk);
        for (int k = 0; k < nblk; k++) begin
            logic [4:0] cnt;
            int         r;
            r = $urandom_range(0, 19);
            if (k != nblk - 1)
                cnt = (r < 5) ? 5'($urandom_range(0, 16)) : 5'd16;
            else if (r < 8)
                cnt = 5'd16;
            else if (r == 19)
                cnt = 5'($urandom_range(17, 31));
            else
                cnt = 5'($urandom_range(0, 15));
            queue_request(1'b0, rand128(), k == 0, k == nblk - 1, cnt);
        end
    endtask

    // Decrypt message chained from the IV, ending in a crafted padded block
    task automatic add_decrypt_message(input int nblk);
        logic [127:0] prev_ct;
        logic [127:0] ct;
        int           flaw;
        prev_ct = {reg_iv_hi, reg_iv_lo};
        for (int k = 0; k < nblk - 1; k++) begin
            ct = rand128();
            queue_request(1'b1, ct, k == 0, 1'b0, 5'($urandom_range(0, 16)));
            prev_ct = ct;
        end
        flaw = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
        ct = sm4_rounds(padded_plain($urandom_range(0, 15), flaw) ^ prev_ct, gen_sched, 1'b0);
        queue_request(1'b1, ct, nblk == 1, 1'b1, 5'($urandom_range(0, 16)));
    endtask

    task automatic add_noise();
        queue_request(1'($urandom_range(0, 1)), rand128(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 5'($urandom_range(0, 16)));
    endtask

    // Wait for the block to go idle with every result in
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || cipher_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Sequencer: reset, directed requests, then randomised phases
    initial begin
        int target;
        int r;
        gen_sched = key_schedule({reg_key_hi, reg_key_lo});
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: chaining from the reset value, padding edges, pad checks
        send_idle_max = 3;
        recv_idle_max = 3;
        queue_request(1'b0, '0, 1'b0, 1'b0, 5'd16);
        queue_request(1'b0, '1, 1'b1, 1'b0, 5'd16);
        queue_request(1'b0, '1, 1'b0, 1'b1, 5'd0);
        queue_request(1'b0, rand128(), 1'b0, 1'b1, 5'd15);
        queue_request(1'b0, '1, 1'b0, 1'b1, 5'd16);
        queue_request(1'b0, rand128(), 1'b0, 1'b1, 5'd17);
        queue_request(1'b0, rand128(), 1'b1, 1'b1, 5'd31);
        queue_request(1'b0, rand128(), 1'b0, 1'b0, 5'd5);
        queue_request(1'b1, '1, 1'b1, 1'b0, 5'd16);
        queue_request(1'b1, '0, 1'b0, 1'b0, 5'd3);
        queue_request(1'b1, '0, 1'b1, 1'b1, 5'd16);
        queue_decrypt_of(padded_plain(0, 0), 5'd16);
        queue_decrypt_of(padded_plain(15, 0), 5'd0);
        queue_decrypt_of(padded_plain(7, 0), 5'd31);
        queue_decrypt_of(padded_plain(9, 1), 5'd16);
        queue_decrypt_of(padded_plain(4, 2), 5'd16);
        queue_decrypt_of({120'd0, 8'hff}, 5'd16);
        queue_decrypt_of(padded_plain(2, 3), 5'd16);
        queue_decrypt_of(padded_plain(0, 3), 5'd16);
        queue_decrypt_of(padded_plain(16 - 1, 3), 5'd16);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            // reprogram while idle; extremes first, then random settings
            case (ph)
                0: begin
                    write_reg(sm4cbc_pkg::CFG_KEY_HIGH, '0);
                    write_reg(sm4cbc_pkg::CFG_KEY_LOW,  '0);
                    write_reg(sm4cbc_pkg::CFG_IV_HIGH,  '1);
                    write_reg(sm4cbc_pkg::CFG_IV_LOW,   '1);
                    send_idle_max = 14; recv_idle_max = 14;
                end
                1: begin
                    write_reg(sm4cbc_pkg::CFG_KEY_HIGH, '1);
                    write_reg(sm4cbc_pkg::CFG_KEY_LOW,  '1);
                    write_reg(sm4cbc_pkg::CFG_IV_HIGH,  '0);
                    write_reg(sm4cbc_pkg::CFG_IV_LOW,   '0);
                    send_idle_max = 0; recv_idle_max = 0;
                end
                4: begin
                    write_reg(sm4cbc_pkg::CFG_KEY_LOW, {$urandom, $urandom});
                    write_reg(sm4cbc_pkg::CFG_IV_HIGH, {$urandom, $urandom});
                    send_idle_max = 14; recv_idle_max = 0;
                end
                default: begin
                    write_reg(sm4cbc_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
                    write_reg(sm4cbc_pkg::CFG_KEY_LOW,  {$urandom, $urandom});
                    write_reg(sm4cbc_pkg::CFG_IV_HIGH,  {$urandom, $urandom});
                    write_reg(sm4cbc_pkg::CFG_IV_LOW,   {$urandom, $urandom});
                    send_idle_max = (ph == 3) ? 14 : 0;
                    recv_idle_max = (ph == 2) ? 5 : 14;
                end
            endcase

            // mostly well-formed messages, some loose requests
            target = queued_count + PHASE_ITEMS;
            while (queued_count < target) begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    add_encrypt_message($urandom_range(1, 4));
                else if (r < 85)
                    add_decrypt_message($urandom_range(1, 4));
                else
                    add_noise();
            end

            // back-pressure the results while requests keep coming
            if (ph == 2)
                hold_asks++;
            wait_drained();
        end

        repeat (120) @(posedge i_clk);
        if (cipher_results.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", cipher_results.size()));
        if (fault_count == 0)
            $display("sm4_cbc_block_cipher regression: pass");
        else
            $display("sm4_cbc_block_cipher regression: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/core/sm4cbc_pkg.sv
rtl/core/sm4cbc_rkey_store.sv
rtl/core/sm4_cbc_block_cipher.sv
dv/sm4_cbc_block_cipher_tb.sv
